>>> design/pic_pkg.sv
// Shared types and constants for the programmable interrupt controller.
package pic_pkg;

	localparam int unsigned LINES      = 8;
	localparam int unsigned LINE_W     = 3;
	localparam int unsigned VEC_HIGH_W = 5;

	// Item kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_LEVEL = 2'd2;
	localparam logic [1:0] KIND_ACK   = 2'd3;

	// OCW2 command codes in bits 7..5.
	localparam logic [2:0] OCW2_ROT_AUTO_CLR = 3'd0;
	localparam logic [2:0] OCW2_EOI          = 3'd1;
	localparam logic [2:0] OCW2_NOP          = 3'd2;
	localparam logic [2:0] OCW2_EOI_SPEC     = 3'd3;
	localparam logic [2:0] OCW2_ROT_AUTO_SET = 3'd4;
	localparam logic [2:0] OCW2_EOI_ROT      = 3'd5;
	localparam logic [2:0] OCW2_SET_PRIO     = 3'd6;
	localparam logic [2:0] OCW2_EOI_SPEC_ROT = 3'd7;

	// Init sequence stages.
	localparam logic [1:0] STAGE_IDLE    = 2'd0;
	localparam logic [1:0] STAGE_VECTOR  = 2'd1;
	localparam logic [1:0] STAGE_CASCADE = 2'd2;
	localparam logic [1:0] STAGE_MODE    = 2'd3;

	localparam logic [7:0] POLL_FLAG = 8'h80;
	localparam logic [7:0] MASK_ALL  = 8'hFF;

	// Configuration register index.
	localparam logic [0:0] REG_LEVEL_MODE = 1'b0;

	typedef struct packed {
		logic              found;
		logic [LINE_W-1:0] line;
	} prio_t;

endpackage

>>> design/programmable_interrupt_controller.sv
// Top level of the eight-line programmable interrupt controller.
// An input register feeds one pass of logic into a result register.
// Throughput: one item per cycle while no result beat is stalled.
// A stalled result beat holds the item in the input register, which stalls the item channel.
// The rotating priority encode of the updated request, service and mask bits sets the path.
// Reset (arst_n low) clears all state, sets every mask bit and empties both registers.
module programmable_interrupt_controller (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Item channel.
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic        port_sel,
	input  logic [7:0]  data,
	input  logic [2:0]  line,
	input  logic        level,
	// Result channel.
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  read_data,
	output logic        irq_pending,
	output logic [2:0]  int_line,
	output logic [7:0]  int_vector
);

	// ------------------------------------------------------------------
	// Configuration register. Only the level mode mask exists; writes to
	// any other address are dropped and read back as zero.
	// ------------------------------------------------------------------
	logic [7:0] level_mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_mode_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == pic_pkg::REG_LEVEL_MODE) begin
			level_mode_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr == pic_pkg::REG_LEVEL_MODE) ? {24'd0, level_mode_q} : '0;

	// ------------------------------------------------------------------
	// Input register. The item waits here until the result register can
	// take its result; the state is updated in the same cycle.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic       port_sel_s1;
	logic [7:0] data_s1;
	logic [2:0] line_s1;
	logic       level_s1;
	logic       advance;

	// The result register is blocked only when it holds a beat that is stalled.
	assign advance    = valid_s1 && !(result_valid && result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			kind_s1     <= kind;
			port_sel_s1 <= port_sel;
			data_s1     <= data;
			line_s1     <= line;
			level_s1    <= level;
		end
	end

	// ------------------------------------------------------------------
	// Controller state.
	// ------------------------------------------------------------------
	logic [7:0] req_q, svc_q, mask_q;
	logic [pic_pkg::VEC_HIGH_W-1:0] vec_high_q;
	logic [2:0] lrs_q;
	logic [1:0] init_stage_q;
	logic       in_init_q, need_icw4_q, auto_end_q, spec_mask_q, poll_q, rot_auto_q;

	logic [7:0] req_n, svc_n, mask_n;
	logic [pic_pkg::VEC_HIGH_W-1:0] vec_high_n;
	logic [2:0] lrs_n;
	logic [1:0] init_stage_n;
	logic       in_init_n, need_icw4_n, auto_end_n, spec_mask_n, poll_n, rot_auto_n;

	// Highest-ranked line in service, used by the non-specific EOI commands.
	pic_pkg::prio_t top_svc;
	pic_prio u_top_svc (
		.req    (svc_q),
		.blk    (8'd0),
		.start  (lrs_q),
		.result (top_svc)
	);

	always_comb begin
		req_n        = req_q;
		svc_n        = svc_q;
		mask_n       = mask_q;
		vec_high_n   = vec_high_q;
		lrs_n        = lrs_q;
		init_stage_n = init_stage_q;
		in_init_n    = in_init_q;
		need_icw4_n  = need_icw4_q;
		auto_end_n   = auto_end_q;
		spec_mask_n  = spec_mask_q;
		poll_n       = poll_q;
		rot_auto_n   = rot_auto_q;

		unique case (kind_s1)
			pic_pkg::KIND_WRITE: begin
				if (port_sel_s1) begin
					// Data port: init words while initializing, else the mask.
					if (!in_init_q) begin
						mask_n = data_s1;
					end else begin
						unique case (init_stage_q)
							pic_pkg::STAGE_VECTOR: begin
								vec_high_n   = data_s1[7:3];
								init_stage_n = pic_pkg::STAGE_CASCADE;
							end
							pic_pkg::STAGE_CASCADE: begin
								if (need_icw4_q) begin
									init_stage_n = pic_pkg::STAGE_MODE;
								end else begin
									in_init_n    = 1'b0;
									init_stage_n = pic_pkg::STAGE_IDLE;
								end
							end
							pic_pkg::STAGE_MODE: begin
								auto_end_n   = data_s1[1];
								in_init_n    = 1'b0;
								init_stage_n = pic_pkg::STAGE_IDLE;
							end
							pic_pkg::STAGE_IDLE: begin
							end
						endcase
					end
				end else if (data_s1[4]) begin
					// ICW1 restarts initialization; polling survives it.
					req_n        = '0;
					svc_n        = '0;
					mask_n       = '0;
					auto_end_n   = 1'b0;
					lrs_n        = '0;
					spec_mask_n  = 1'b0;
					rot_auto_n   = 1'b0;
					need_icw4_n  = data_s1[0];
					in_init_n    = 1'b1;
					init_stage_n = pic_pkg::STAGE_VECTOR;
				end else if (data_s1[3]) begin
					// OCW3: poll and special mask controls.
					if (data_s1[1]) poll_n = data_s1[2];
					if (data_s1[6]) spec_mask_n = data_s1[5];
				end else begin
					// OCW2: end of interrupt, rotation and priority commands.
					unique case (data_s1[7:5])
						pic_pkg::OCW2_EOI, pic_pkg::OCW2_EOI_ROT: begin
							if (top_svc.found) begin
								svc_n[top_svc.line] = 1'b0;
								if (data_s1[7:5] == pic_pkg::OCW2_EOI_ROT)
									lrs_n = top_svc.line + 3'd1;
							end
						end
						pic_pkg::OCW2_EOI_SPEC, pic_pkg::OCW2_EOI_SPEC_ROT: begin
							svc_n[data_s1[2:0]] = 1'b0;
							if (data_s1[7:5] == pic_pkg::OCW2_EOI_SPEC_ROT)
								lrs_n = data_s1[2:0] + 3'd1;
						end
						pic_pkg::OCW2_ROT_AUTO_CLR: rot_auto_n = 1'b0;
						pic_pkg::OCW2_ROT_AUTO_SET: rot_auto_n = 1'b1;
						pic_pkg::OCW2_SET_PRIO:     lrs_n = data_s1[2:0] + 3'd1;
						pic_pkg::OCW2_NOP: begin
						end
					endcase
				end
			end
			pic_pkg::KIND_READ: begin
				// A poll read of the command port ends poll mode.
				if (!port_sel_s1 && poll_q) poll_n = 1'b0;
			end
			pic_pkg::KIND_LEVEL: begin
				// Edge-triggered lines keep their request when the level drops.
				if (level_s1) begin
					req_n[line_s1] = 1'b1;
				end else if (level_mode_q[line_s1]) begin
					req_n[line_s1] = 1'b0;
				end
			end
			pic_pkg::KIND_ACK: begin
				req_n[line_s1] = 1'b0;
				svc_n[line_s1] = 1'b1;
				if (auto_end_q) begin
					svc_n[line_s1] = 1'b0;
					if (rot_auto_q) lrs_n = line_s1 + 3'd1;
				end
			end
		endcase
	end

	// Serviceable line on the updated state. Without special masking a line
	// in service blocks every line ranked below it (full nesting).
	pic_pkg::prio_t serv;
	logic [7:0]     serv_req;
	logic [7:0]     serv_blk;

	assign serv_req = req_n & ~mask_n & ~svc_n;
	assign serv_blk = spec_mask_n ? 8'd0 : svc_n;

	pic_prio u_serv (
		.req    (serv_req),
		.blk    (serv_blk),
		.start  (lrs_n),
		.result (serv)
	);

	logic [7:0] rd_n;
	logic [2:0] line_n;

	assign line_n = serv.found ? serv.line : 3'd0;

	always_comb begin
		rd_n = '0;
		if (kind_s1 == pic_pkg::KIND_READ) begin
			if (port_sel_s1) begin
				rd_n = mask_q;
			end else if (poll_q) begin
				rd_n = serv.found ? (pic_pkg::POLL_FLAG | {5'd0, serv.line}) : 8'd0;
			end else begin
				rd_n = req_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q        <= '0;
			svc_q        <= '0;
			mask_q       <= pic_pkg::MASK_ALL;
			vec_high_q   <= '0;
			lrs_q        <= '0;
			init_stage_q <= pic_pkg::STAGE_IDLE;
			in_init_q    <= 1'b0;
			need_icw4_q  <= 1'b0;
			auto_end_q   <= 1'b0;
			spec_mask_q  <= 1'b0;
			poll_q       <= 1'b0;
			rot_auto_q   <= 1'b0;
		end else if (advance) begin
			req_q        <= req_n;
			svc_q        <= svc_n;
			mask_q       <= mask_n;
			vec_high_q   <= vec_high_n;
			lrs_q        <= lrs_n;
			init_stage_q <= init_stage_n;
			in_init_q    <= in_init_n;
			need_icw4_q  <= need_icw4_n;
			auto_end_q   <= auto_end_n;
			spec_mask_q  <= spec_mask_n;
			poll_q       <= poll_n;
			rot_auto_q   <= rot_auto_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register. It takes a new beat whenever the item stage
	// advances and drops its valid once the beat has been taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data   <= rd_n;
			irq_pending <= serv.found;
			int_line    <= line_n;
			int_vector  <= {vec_high_n, line_n};
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item stage stalled while the result register was free");

	a_init_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_init_q == (init_stage_q != pic_pkg::STAGE_IDLE)))
		else $error("init stage and init flag disagree");

	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !irq_pending) |-> (int_line == 3'd0))
		else $error("line reported with nothing pending");

	a_vector_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int_vector[2:0] == int_line))
		else $error("vector low bits do not match the reported line");

endmodule

>>> design/pic_prio.sv
// Rotating priority encoder over eight lines with an optional blocking set.
module pic_prio (
	input  logic [7:0]                   req,
	input  logic [7:0]                   blk,
	input  logic [pic_pkg::LINE_W-1:0]   start,
	output pic_pkg::prio_t               result
);

	// The scan starts at start and walks upward modulo eight. The first line
	// with a request wins; a blocking line met first ends the scan empty.
	always_comb begin
		logic                        done;
		logic [pic_pkg::LINE_W-1:0]  idx;
		done = 1'b0;
		idx = '0;
		result.found = 1'b0;
		result.line = '0;
		for (int k = 0; k < pic_pkg::LINES; k++) begin
			idx = start + pic_pkg::LINE_W'(k);
			if (!done) begin
				if (req[idx]) begin
					result.found = 1'b1;
					result.line = idx;
					done = 1'b1;
				end else if (blk[idx]) begin
					done = 1'b1;
				end
			end
		end
	end

endmodule
